@@ hdl/arbt_pkg.sv @@
// Package for the affine rectangle bounding-box core.
// Holds payload/config structs, register indexes and saturation helpers.
// No dependencies.
package arbt_pkg;

    localparam int DATA_W        = 32;
    localparam int SIZE_W        = 31;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int ACC_W         = PROD_W + 2;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_CORNERS   = 4;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_XX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_XY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_YX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_YY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;

    typedef struct packed {
        logic signed [DATA_W-1:0] rect_left;
        logic signed [DATA_W-1:0] rect_top;
        logic signed [DATA_W-1:0] rect_width;
        logic signed [DATA_W-1:0] rect_height;
    } t_rect_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] box_left;
        logic signed [DATA_W-1:0] box_top;
        logic        [SIZE_W-1:0] box_width;
        logic        [SIZE_W-1:0] box_height;
    } t_box_out;

    typedef struct packed {
        logic signed [DATA_W-1:0] coef_xx;
        logic signed [DATA_W-1:0] coef_xy;
        logic signed [DATA_W-1:0] offset_x;
        logic signed [DATA_W-1:0] coef_yx;
        logic signed [DATA_W-1:0] coef_yy;
        logic signed [DATA_W-1:0] offset_y;
    } t_coefs;

    // per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    // saturate a signed value of width ACC_W to DATA_W bits
    function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DATA_W:0]       top_bits;
        logic signed [DATA_W-1:0]    res;
        top_bits = v[ACC_W-1:DATA_W-1];
        if ((&top_bits) || !(|top_bits)) begin
            res = v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_add32(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0]   s;
        logic signed [DATA_W-1:0] res;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] == s[DATA_W-1]) begin
            res = s[DATA_W-1:0];
        end else if (s[DATA_W]) begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

@@ hdl/arbt_cfg_regs.sv @@
// Configuration register file: six affine coefficients with reset values.
// Depends on arbt_pkg.
module arbt_cfg_regs #(
    parameter int FRAC_BITS = arbt_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [arbt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [arbt_pkg::DATA_W-1:0]         i_cfg_data,
    output logic                                o_cfg_ready,
    output arbt_pkg::t_coefs                    o_coefs
);

    localparam logic signed [arbt_pkg::DATA_W-1:0] ONE =
        arbt_pkg::DATA_W'(1) << FRAC_BITS;

    arbt_pkg::t_coefs r_coefs;

    assign o_cfg_ready = 1'b1;
    assign o_coefs     = r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.coef_xx  <= ONE;
            r_coefs.coef_xy  <= '0;
            r_coefs.offset_x <= '0;
            r_coefs.coef_yx  <= '0;
            r_coefs.coef_yy  <= ONE;
            r_coefs.offset_y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                arbt_pkg::REG_COEF_XX:  r_coefs.coef_xx  <= i_cfg_data;
                arbt_pkg::REG_COEF_XY:  r_coefs.coef_xy  <= i_cfg_data;
                arbt_pkg::REG_OFFSET_X: r_coefs.offset_x <= i_cfg_data;
                arbt_pkg::REG_COEF_YX:  r_coefs.coef_yx  <= i_cfg_data;
                arbt_pkg::REG_COEF_YY:  r_coefs.coef_yy  <= i_cfg_data;
                arbt_pkg::REG_OFFSET_Y: r_coefs.offset_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/arbt_mul_stage.sv @@
// Corner formation and product stage: registers the edge coordinates x0, x1, y0, y1,
// then the shifted products of each coefficient with both of its coordinates. Depends on arbt_pkg.
module arbt_mul_stage #(
    parameter int FRAC_BITS = arbt_pkg::FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  arbt_pkg::t_pipe_en                          i_en,
    input  arbt_pkg::t_rect_in                          i_rect,
    input  arbt_pkg::t_coefs                            i_coefs,
    output logic signed [arbt_pkg::PROD_W-1:0]          o_ax [2],
    output logic signed [arbt_pkg::PROD_W-1:0]          o_by [2],
    output logic signed [arbt_pkg::PROD_W-1:0]          o_cx [2],
    output logic signed [arbt_pkg::PROD_W-1:0]          o_dy [2]
);

    logic signed [arbt_pkg::DATA_W-1:0] r_x [2];
    logic signed [arbt_pkg::DATA_W-1:0] r_y [2];
    logic signed [arbt_pkg::PROD_W-1:0] r_ax [2];
    logic signed [arbt_pkg::PROD_W-1:0] r_by [2];
    logic signed [arbt_pkg::PROD_W-1:0] r_cx [2];
    logic signed [arbt_pkg::PROD_W-1:0] r_dy [2];

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_x[0] <= i_rect.rect_left;
            r_y[0] <= i_rect.rect_top;
            r_x[1] <= arbt_pkg::sat_add32(i_rect.rect_left, i_rect.rect_width);
            r_y[1] <= arbt_pkg::sat_add32(i_rect.rect_top, i_rect.rect_height);
        end
    end

    // full products, arithmetic shift rounds toward minus infinity
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            for (int k = 0; k < 2; k++) begin
                r_ax[k] <= (arbt_pkg::PROD_W'(i_coefs.coef_xx) * arbt_pkg::PROD_W'(r_x[k]))
                           >>> FRAC_BITS;
                r_by[k] <= (arbt_pkg::PROD_W'(i_coefs.coef_xy) * arbt_pkg::PROD_W'(r_y[k]))
                           >>> FRAC_BITS;
                r_cx[k] <= (arbt_pkg::PROD_W'(i_coefs.coef_yx) * arbt_pkg::PROD_W'(r_x[k]))
                           >>> FRAC_BITS;
                r_dy[k] <= (arbt_pkg::PROD_W'(i_coefs.coef_yy) * arbt_pkg::PROD_W'(r_y[k]))
                           >>> FRAC_BITS;
            end
        end
    end

    assign o_ax = r_ax;
    assign o_by = r_by;
    assign o_cx = r_cx;
    assign o_dy = r_dy;

endmodule

@@ hdl/arbt_box_stage.sv @@
// Corner sum and bounding-box stage: saturated affine sums per corner,
// then min/max and saturated size into the result register. Depends on arbt_pkg.
module arbt_box_stage (
    input  logic                                        i_clk,
    input  arbt_pkg::t_pipe_en                          i_en,
    input  arbt_pkg::t_coefs                            i_coefs,
    input  logic signed [arbt_pkg::PROD_W-1:0]          i_ax [2],
    input  logic signed [arbt_pkg::PROD_W-1:0]          i_by [2],
    input  logic signed [arbt_pkg::PROD_W-1:0]          i_cx [2],
    input  logic signed [arbt_pkg::PROD_W-1:0]          i_dy [2],
    output arbt_pkg::t_box_out                          o_box
);

    localparam int NC = arbt_pkg::NUM_CORNERS;
    localparam int DW = arbt_pkg::DATA_W;
    localparam int AW = arbt_pkg::ACC_W;
    localparam int SW = arbt_pkg::SIZE_W;

    logic signed [DW-1:0] r_px [NC];
    logic signed [DW-1:0] r_py [NC];
    logic signed [DW-1:0] n_px [NC];
    logic signed [DW-1:0] n_py [NC];
    arbt_pkg::t_box_out   r_box;
    arbt_pkg::t_box_out   n_box;

    // corner k: x index k[1], y index k[0]
    always_comb begin
        for (int k = 0; k < NC; k++) begin
            n_px[k] = arbt_pkg::sat_acc(AW'(i_ax[k/2]) + AW'(i_by[k%2]) + AW'(i_coefs.offset_x));
            n_py[k] = arbt_pkg::sat_acc(AW'(i_cx[k/2]) + AW'(i_dy[k%2]) + AW'(i_coefs.offset_y));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_px <= n_px;
            r_py <= n_py;
        end
    end

    always_comb begin
        logic signed [DW-1:0] minx, maxx, miny, maxy;
        logic signed [DW:0]   dx, dy;
        minx = r_px[0];
        maxx = r_px[0];
        miny = r_py[0];
        maxy = r_py[0];
        for (int k = 1; k < NC; k++) begin
            if (r_px[k] < minx) minx = r_px[k];
            if (r_px[k] > maxx) maxx = r_px[k];
            if (r_py[k] < miny) miny = r_py[k];
            if (r_py[k] > maxy) maxy = r_py[k];
        end
        dx = {maxx[DW-1], maxx} - {minx[DW-1], minx};
        dy = {maxy[DW-1], maxy} - {miny[DW-1], miny};
        n_box.box_left   = minx;
        n_box.box_top    = miny;
        n_box.box_width  = (|dx[DW:SW]) ? {SW{1'b1}} : dx[SW-1:0];
        n_box.box_height = (|dy[DW:SW]) ? {SW{1'b1}} : dy[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_box <= n_box;
        end
    end

    assign o_box = r_box;

endmodule

@@ hdl/affine_rect_bounds_transform_core.sv @@
// Affine rectangle bounding-box core, top level.
// Stages in order: edge coordinates, products, corner sums, box result register.
// Throughput: one transaction per cycle unless stalled; the four-stage
// pipeline stalls stage by stage from the output, so bubbles are squeezed out.
// Reset (synchronous, active low) clears all stage valids and loads the
// identity matrix with zero offsets.
module affine_rect_bounds_transform_core #(
    parameter int FRAC_BITS = arbt_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  arbt_pkg::t_rect_in                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output arbt_pkg::t_box_out                  o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [arbt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [arbt_pkg::DATA_W-1:0]         i_cfg_data
);

    arbt_pkg::t_coefs   coefs;
    arbt_pkg::t_pipe_en en;
    logic [3:0]         r_vld;
    logic [3:0]         rdy;

    logic signed [arbt_pkg::PROD_W-1:0] ax [2];
    logic signed [arbt_pkg::PROD_W-1:0] by [2];
    logic signed [arbt_pkg::PROD_W-1:0] cx [2];
    logic signed [arbt_pkg::PROD_W-1:0] dy [2];

    assign rdy[3] = !r_vld[3] || !i_out_stall;
    assign rdy[2] = !r_vld[2] || rdy[3];
    assign rdy[1] = !r_vld[1] || rdy[2];
    assign rdy[0] = !r_vld[0] || rdy[1];

    assign en.s1 = rdy[0];
    assign en.s2 = rdy[1];
    assign en.s3 = rdy[2];
    assign en.s4 = rdy[3];

    assign o_in_stall  = !rdy[0];
    assign o_out_valid = r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_in_valid;
            if (rdy[1]) r_vld[1] <= r_vld[0];
            if (rdy[2]) r_vld[2] <= r_vld[1];
            if (rdy[3]) r_vld[3] <= r_vld[2];
        end
    end

    arbt_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_coefs     (coefs)
    );

    arbt_mul_stage #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_rect  (i_in),
        .i_coefs (coefs),
        .o_ax    (ax),
        .o_by    (by),
        .o_cx    (cx),
        .o_dy    (dy)
    );

    arbt_box_stage u_box (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coefs (coefs),
        .i_ax    (ax),
        .i_by    (by),
        .i_cx    (cx),
        .i_dy    (dy),
        .o_box   (o_out)
    );

endmodule

@@ bench/tb_box_pkg.sv @@
// Scoreboard for the affine rectangle bounding-box core: predicts one box per
// accepted rectangle from its own copy of the six coefficient registers.
// Depends on arbt_pkg for the payload types and register indexes.
`timescale 1ns / 1ps

package tb_box_pkg;

    import arbt_pkg::*;

    localparam longint WORD_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint WORD_LO = 64'shFFFF_FFFF_8000_0000;

    class box_scoreboard;

        localparam int SHIFT     = FRAC_BITS_DEF;
        localparam int PRINT_CAP = 40;

        longint   w_xx, w_xy, off_x, w_yx, w_yy, off_y;
        t_box_out boxes_due[$];
        int       fails;
        int       boxes_seen;

        function new();
            w_xx       = longint'(1) << SHIFT;
            w_xy       = 0;
            off_x      = 0;
            w_yx       = 0;
            w_yy       = longint'(1) << SHIFT;
            off_y      = 0;
            fails      = 0;
            boxes_seen = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            longint v;
            v = longint'($signed(data));
            case (idx)
                REG_COEF_XX:  w_xx  = v;
                REG_COEF_XY:  w_xy  = v;
                REG_OFFSET_X: off_x = v;
                REG_COEF_YX:  w_yx  = v;
                REG_COEF_YY:  w_yy  = v;
                REG_OFFSET_Y: off_y = v;
                default: ;
            endcase
        endfunction

        function longint clamp_word(longint v);
            if (v > WORD_HI) return WORD_HI;
            if (v < WORD_LO) return WORD_LO;
            return v;
        endfunction

        // arithmetic shift of the exact product floors toward minus infinity
        function longint scaled(longint w, longint v);
            longint p;
            p = w * v;
            return p >>> SHIFT;
        endfunction

        function longint map_axis(longint wa, longint wb, longint off, longint x, longint y);
            return clamp_word(scaled(wa, x) + scaled(wb, y) + off);
        endfunction

        function logic [SIZE_W-1:0] extent(longint lo, longint hi);
            longint d;
            d = hi - lo;
            if (d > WORD_HI) d = WORD_HI;
            return d[SIZE_W-1:0];
        endfunction

        function void note_rect(t_rect_in r);
            longint   x0, y0, x1, y1, px, py;
            longint   lox, hix, loy, hiy;
            longint   cx[4];
            longint   cy[4];
            t_box_out b;
            x0 = longint'($signed(r.rect_left));
            y0 = longint'($signed(r.rect_top));
            x1 = clamp_word(x0 + longint'($signed(r.rect_width)));
            y1 = clamp_word(y0 + longint'($signed(r.rect_height)));
            cx = '{x0, x0, x1, x1};
            cy = '{y0, y1, y0, y1};
            lox = 0; hix = 0; loy = 0; hiy = 0;
            for (int i = 0; i < 4; i++) begin
                px = map_axis(w_xx, w_xy, off_x, cx[i], cy[i]);
                py = map_axis(w_yx, w_yy, off_y, cx[i], cy[i]);
                if (i == 0 || px < lox) lox = px;
                if (i == 0 || px > hix) hix = px;
                if (i == 0 || py < loy) loy = py;
                if (i == 0 || py > hiy) hiy = py;
            end
            b.box_left   = lox[DATA_W-1:0];
            b.box_top    = loy[DATA_W-1:0];
            b.box_width  = extent(lox, hix);
            b.box_height = extent(loy, hiy);
            boxes_due.push_back(b);
        endfunction

        function int pending();
            return boxes_due.size();
        endfunction

        task report_mismatch(string msg);
            fails++;
            if (fails <= PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        task check_box(t_box_out got);
            t_box_out want;
            boxes_seen++;
            if (boxes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected box transaction %0d: %h",
                    boxes_seen, got));
                return;
            end
            want = boxes_due.pop_front();
            if (got.box_left !== want.box_left)
                report_mismatch($sformatf("box %0d box_left got %h want %h",
                    boxes_seen, got.box_left, want.box_left));
            if (got.box_top !== want.box_top)
                report_mismatch($sformatf("box %0d box_top got %h want %h",
                    boxes_seen, got.box_top, want.box_top));
            if (got.box_width !== want.box_width)
                report_mismatch($sformatf("box %0d box_width got %h want %h",
                    boxes_seen, got.box_width, want.box_width));
            if (got.box_height !== want.box_height)
                report_mismatch($sformatf("box %0d box_height got %h want %h",
                    boxes_seen, got.box_height, want.box_height));
        endtask

        task flush_leftover();
            if (boxes_due.size() != 0)
                report_mismatch($sformatf("%0d box transactions never arrived",
                    boxes_due.size()));
        endtask

    endclass

endpackage

@@ bench/tb_top.sv @@
// Top-level testbench for affine_rect_bounds_transform_core: directed corner
// cases, then random rectangles under many coefficient settings with gaps/stalls.
// Depends on arbt_pkg and tb_box_pkg (scoreboard).
`timescale 1ns / 1ps

module tb_top;

    import arbt_pkg::*;
    import tb_box_pkg::*;

    localparam int SETTLE_CYCLES     = 8;
    localparam int ITEMS_PER_SETTING = 100;
    localparam int NUM_PHASES        = 9;
    localparam int HOLD_PHASE        = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_ONE    = 32'h0001_0000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_rect_in             i_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_box_out             o_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;

    box_scoreboard sb;
    int            gap_mode;
    int            stall_mode;
    int            stall_left;
    int            rects_sent;
    int            settings_done;

    affine_rect_bounds_transform_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TIMEOUT");
        $display("affine_rect_bounds_transform_core: mismatch");
        $finish;
    end

    // mostly short bursts, now and then a long one
    function automatic int burst_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    function automatic int gap_len();
        if (gap_mode == 0) return 0;
        if ($urandom_range(0, 99) < (gap_mode == 1 ? 60 : 30)) return 0;
        return burst_len();
    endfunction

    function automatic logic [DATA_W-1:0] small_word(int bits);
        return 32'($urandom_range(0, 2 ** (bits + 1))) - 32'(2 ** bits);
    endfunction

    function automatic logic [DATA_W-1:0] pick_extreme();
        case ($urandom_range(0, 6))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return '1;
            4: return 32'd1;
            5: return Q_ONE;
            default: return -Q_ONE;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_coef(int kind);
        case (kind)
            0: return small_word(18);
            1: return $urandom;
            default: return pick_extreme();
        endcase
    endfunction

    function automatic t_rect_in mk_rect(logic [DATA_W-1:0] l, logic [DATA_W-1:0] t,
                                         logic [DATA_W-1:0] w, logic [DATA_W-1:0] h);
        t_rect_in r;
        r.rect_left   = l;
        r.rect_top    = t;
        r.rect_width  = w;
        r.rect_height = h;
        return r;
    endfunction

    function automatic t_rect_in rand_rect();
        t_rect_in r;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            r = mk_rect(small_word(22), small_word(22),
                        32'($urandom_range(0, 1 << 21)), 32'($urandom_range(0, 1 << 21)));
            if ($urandom_range(0, 5) == 0) r.rect_width = -r.rect_width;
            if ($urandom_range(0, 5) == 0) r.rect_height = -r.rect_height;
        end else if (pick < 50) begin
            r = mk_rect($urandom, $urandom, '0, '0);
        end else if (pick < 62) begin
            r = mk_rect(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
        end else begin
            r = mk_rect($urandom, $urandom, $urandom, $urandom);
        end
        return r;
    endfunction

    task automatic send_rect(input t_rect_in r);
        int gap;
        i_in       <= r;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_rect(r);
        rects_sent++;
        @(negedge i_clk);
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    // spare indexes have no register behind them; writes there must be dropped
    task automatic load_matrix(input t_coefs m, input bit with_spares);
        if (with_spares) write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_COEF_XX, m.coef_xx);
        write_reg(REG_COEF_XY, m.coef_xy);
        write_reg(REG_OFFSET_X, m.offset_x);
        write_reg(REG_COEF_YX, m.coef_yx);
        write_reg(REG_COEF_YY, m.coef_yy);
        write_reg(REG_OFFSET_Y, m.offset_y);
        if (with_spares) write_reg(REG_SPARE_HI, $urandom);
        i_cfg_valid <= 1'b0;
        settings_done++;
    endtask

    initial begin
        bit stall_now;
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_now = 1'b1;
                stall_left--;
            end else if (stall_mode != 0 &&
                         $urandom_range(0, 99) < (stall_mode == 1 ? 15 : 40)) begin
                stall_left = burst_len() - 1;
                stall_now  = 1'b1;
            end else begin
                stall_now = 1'b0;
            end
            i_out_stall <= stall_now;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_box(o_out);
    end

    initial begin
        t_coefs m;
        sb            = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        gap_mode      = 0;
        stall_mode    = 0;
        rects_sent    = 0;
        settings_done = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, identity matrix from reset
        gap_mode   = 1;
        stall_mode = 1;
        send_rect(mk_rect('0, '0, '0, '0));
        send_rect(mk_rect(WORD_MAX, WORD_MAX, '0, '0));
        send_rect(mk_rect(WORD_MIN, WORD_MIN, '0, '0));
        send_rect(mk_rect(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
        send_rect(mk_rect(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
        send_rect(mk_rect(WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN));
        send_rect(mk_rect(WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX));
        send_rect(mk_rect(32'h000A_0000, 32'h0005_0000, -32'h0003_0000, -32'h0002_0000));
        send_rect(mk_rect(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA));
        send_rect(mk_rect('1, 32'd1, '1, 32'd1));
        send_rect(mk_rect($urandom, $urandom, '0, '0));
        send_rect(mk_rect($urandom, $urandom, $urandom, $urandom));
        send_rect(mk_rect($urandom, $urandom, $urandom, $urandom));
        wait_drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    m = '{Q_ONE, '0, '0, '0, Q_ONE, '0};
                    gap_mode = 1; stall_mode = 1;
                end
                1: begin
                    m = '{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX};
                    gap_mode = 0; stall_mode = 0;
                end
                2: begin
                    m = '{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN};
                    gap_mode = 2; stall_mode = 2;
                end
                3: begin
                    m = '{'0, '0, $urandom, '0, '0, $urandom};
                    gap_mode = 1; stall_mode = 2;
                end
                default: begin
                    m.coef_xx  = rand_coef($urandom_range(0, 2));
                    m.coef_xy  = rand_coef($urandom_range(0, 2));
                    m.offset_x = rand_coef($urandom_range(0, 2));
                    m.coef_yx  = rand_coef($urandom_range(0, 2));
                    m.coef_yy  = rand_coef($urandom_range(0, 2));
                    m.offset_y = rand_coef($urandom_range(0, 2));
                    gap_mode   = $urandom_range(0, 2);
                    stall_mode = $urandom_range(0, 2);
                end
            endcase
            load_matrix(m, p == 0);
            for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
                if (p == HOLD_PHASE && k == ITEMS_PER_SETTING / 2) wait_drain();
                send_rect(rand_rect());
            end
            wait_drain();
        end

        sb.flush_leftover();
        $display("Checked %0d boxes from %0d rectangles: reset matrix plus %0d loaded settings",
                 sb.boxes_seen, rects_sent, settings_done);
        $display("(saturating extremes, zero matrix, random coefficients, gaps and stalls).");
        if (sb.fails == 0) begin
            $display("affine_rect_bounds_transform_core: match");
        end else begin
            $display("%0d mismatches", sb.fails);
            $display("affine_rect_bounds_transform_core: mismatch");
        end
        $finish;
    end

endmodule
